// ----- rtl/wncu_pkg.sv -----
// ----------------------------------------------------------------------------
// wncu_pkg: shared types and constants of the numeric conversion unit
// Opcodes in Wasm order and the bundles passed between pipeline stages.
// ----------------------------------------------------------------------------
package wncu_pkg;

  localparam int FUNC_W = 5;
  localparam int DATA_W = 64;

  localparam logic [FUNC_W-1:0] OP_WRAP      = 5'd0;
  localparam logic [FUNC_W-1:0] OP_T32_F32S  = 5'd1;
  localparam logic [FUNC_W-1:0] OP_T32_F32U  = 5'd2;
  localparam logic [FUNC_W-1:0] OP_T32_F64S  = 5'd3;
  localparam logic [FUNC_W-1:0] OP_T32_F64U  = 5'd4;
  localparam logic [FUNC_W-1:0] OP_EXT_S     = 5'd5;
  localparam logic [FUNC_W-1:0] OP_EXT_U     = 5'd6;
  localparam logic [FUNC_W-1:0] OP_T64_F32S  = 5'd7;
  localparam logic [FUNC_W-1:0] OP_T64_F32U  = 5'd8;
  localparam logic [FUNC_W-1:0] OP_T64_F64S  = 5'd9;
  localparam logic [FUNC_W-1:0] OP_T64_F64U  = 5'd10;
  localparam logic [FUNC_W-1:0] OP_F32_I32S  = 5'd11;
  localparam logic [FUNC_W-1:0] OP_F32_I32U  = 5'd12;
  localparam logic [FUNC_W-1:0] OP_F32_I64S  = 5'd13;
  localparam logic [FUNC_W-1:0] OP_F32_I64U  = 5'd14;
  localparam logic [FUNC_W-1:0] OP_DEMOTE    = 5'd15;
  localparam logic [FUNC_W-1:0] OP_F64_I32S  = 5'd16;
  localparam logic [FUNC_W-1:0] OP_F64_I32U  = 5'd17;
  localparam logic [FUNC_W-1:0] OP_F64_I64S  = 5'd18;
  localparam logic [FUNC_W-1:0] OP_F64_I64U  = 5'd19;
  localparam logic [FUNC_W-1:0] OP_PROMOTE   = 5'd20;
  localparam logic [FUNC_W-1:0] OP_I32_REINT = 5'd21;
  localparam logic [FUNC_W-1:0] OP_I64_REINT = 5'd22;
  localparam logic [FUNC_W-1:0] OP_F32_REINT = 5'd23;
  localparam logic [FUNC_W-1:0] OP_F64_REINT = 5'd24;

  // Operation class picked in decode
  localparam logic [2:0] CL_BITS  = 3'd0;  // result fixed in decode
  localparam logic [2:0] CL_TRUNC = 3'd1;
  localparam logic [2:0] CL_CONV  = 3'd2;
  localparam logic [2:0] CL_FLT   = 3'd3;  // demote/promote

  // Decoded item. A normalized magnitude with exponent drives all
  // non-trivial cases: trunc shifts it right, conv/demote/promote round it right.
  typedef struct packed {
    logic [2:0]  cls;
    logic        neg;
    logic        dst64;     // result width 64
    logic        sgn;       // trunc: signed target
    logic        special;   // result already final in res
    logic        trap;
    logic [63:0] res;
    logic [63:0] mag;       // magnitude, msb at bit 63 once normalized
    logic signed [12:0] exp; // unbiased exponent of mag bit 63
  } dec_t;

  // Rounded/shifted mid stage
  typedef struct packed {
    logic        special;
    logic        trap;
    logic [63:0] res;
    logic [2:0]  cls;
    logic        neg;
    logic        dst64;
    logic        sgn;
    logic [63:0] val;       // trunc: integer magnitude; else rounded mant
    logic signed [12:0] exp;
    logic        ovf;       // trunc magnitude beyond 64 bits
  } mid_t;

endpackage

// ----- rtl/wncu_decode.sv -----
// ----------------------------------------------------------------------------
// wncu_decode: field unpack and leading-one normalization
// Splits the operand by opcode and left-aligns the magnitude.
// ----------------------------------------------------------------------------
module wncu_decode (
  input  logic [wncu_pkg::FUNC_W-1:0] func,
  input  logic [wncu_pkg::DATA_W-1:0] operand_bits,
  output wncu_pkg::dec_t               dec
);
  import wncu_pkg::*;

  logic [31:0] lo;
  logic        f64src;
  logic        neg_f;
  logic [10:0] ex;
  logic [51:0] mant;
  logic        exmax;
  logic        ex0;
  logic [63:0] raw_mag;
  logic signed [12:0] raw_exp;
  logic [5:0]  lz;
  logic        found;
  logic [63:0] iv;

  always_comb begin
    lo      = operand_bits[31:0];
    dec     = '0;
    f64src  = 1'b0;
    neg_f   = 1'b0;
    ex      = '0;
    mant    = '0;
    raw_mag = '0;
    raw_exp = '0;
    iv      = '0;
    unique case (func)
      OP_T32_F64S, OP_T32_F64U, OP_T64_F64S, OP_T64_F64U, OP_DEMOTE: f64src = 1'b1;
      default: f64src = 1'b0;
    endcase
    if (f64src) begin
      neg_f = operand_bits[63];
      ex    = operand_bits[62:52];
      mant  = operand_bits[51:0];
      exmax = (ex == 11'h7ff);
    end else begin
      neg_f = lo[31];
      ex    = {3'b0, lo[30:23]};
      mant  = {lo[22:0], 29'b0};
      exmax = (lo[30:23] == 8'hff);
    end
    ex0 = (ex == '0);

    unique case (func)
      OP_WRAP, OP_EXT_U, OP_I32_REINT, OP_F32_REINT: begin
        dec.cls = CL_BITS; dec.special = 1'b1; dec.res = {32'b0, lo};
      end
      OP_EXT_S: begin
        dec.cls = CL_BITS; dec.special = 1'b1; dec.res = {{32{lo[31]}}, lo};
      end
      OP_I64_REINT, OP_F64_REINT: begin
        dec.cls = CL_BITS; dec.special = 1'b1; dec.res = operand_bits;
      end
      OP_T32_F32S, OP_T32_F32U, OP_T32_F64S, OP_T32_F64U,
      OP_T64_F32S, OP_T64_F32U, OP_T64_F64S, OP_T64_F64U: begin
        dec.cls   = CL_TRUNC;
        dec.neg   = neg_f;
        dec.dst64 = (func >= OP_T64_F32S);
        dec.sgn   = (func == OP_T32_F32S) || (func == OP_T32_F64S) ||
                    (func == OP_T64_F32S) || (func == OP_T64_F64S);
        if (exmax) begin
          dec.special = 1'b1; dec.trap = 1'b1;
        end
        raw_mag = ex0 ? 64'b0 : {1'b1, mant, 11'b0};
        raw_exp = f64src ? $signed({2'b0, ex}) - 13'sd1023
                         : $signed({2'b0, ex}) - 13'sd127;
      end
      OP_F32_I32S, OP_F32_I32U, OP_F32_I64S, OP_F32_I64U,
      OP_F64_I32S, OP_F64_I32U, OP_F64_I64S, OP_F64_I64U: begin
        dec.cls   = CL_CONV;
        dec.dst64 = (func >= OP_F64_I32S);
        if ((func == OP_F32_I32S) || (func == OP_F32_I32U) ||
            (func == OP_F64_I32S) || (func == OP_F64_I32U)) begin
          iv = {32'b0, lo};
          if (((func == OP_F32_I32S) || (func == OP_F64_I32S)) && lo[31]) begin
            dec.neg = 1'b1; iv = {32'b0, 32'(-lo)};
          end
        end else begin
          iv = operand_bits;
          if (((func == OP_F32_I64S) || (func == OP_F64_I64S)) && operand_bits[63]) begin
            dec.neg = 1'b1; iv = -operand_bits;
          end
        end
        raw_mag = iv;
        raw_exp = 13'sd63;
        if (iv == '0) begin
          dec.special = 1'b1; dec.res = '0;
        end
      end
      OP_DEMOTE: begin
        dec.cls = CL_FLT; dec.neg = neg_f; dec.dst64 = 1'b0;
        if (exmax) begin
          dec.special = 1'b1;
          dec.res = (mant == '0) ? {32'b0, neg_f, 31'h7f800000}
                                 : {32'b0, neg_f, 8'hff, 1'b1, mant[50:29]};
        end else if (ex0) begin
          dec.special = 1'b1; dec.res = {32'b0, neg_f, 31'b0};
        end
        raw_mag = {1'b1, mant, 11'b0};
        raw_exp = $signed({2'b0, ex}) - 13'sd1023;
      end
      OP_PROMOTE: begin
        dec.cls = CL_FLT; dec.neg = neg_f; dec.dst64 = 1'b1;
        if (exmax) begin
          dec.special = 1'b1;
          dec.res = (mant == '0) ? {neg_f, 63'h7ff0000000000000}
                                 : {neg_f, 12'hfff, mant[50:0]};
        end else if (ex0 && mant == '0) begin
          dec.special = 1'b1; dec.res = {neg_f, 63'b0};
        end
        // subnormal: value = mant[51:29] * 2^-149, lead bit at 63 = 2^-126 slot
        raw_mag = ex0 ? {1'b0, mant[51:29], 40'b0} : {1'b1, mant, 11'b0};
        raw_exp = ex0 ? -13'sd126 : $signed({2'b0, ex}) - 13'sd127;
      end
      default: begin
        dec.cls = CL_BITS; dec.special = 1'b1; dec.res = '0;
      end
    endcase

    // leading-zero count over the magnitude (parallel priority search for the leading one)
    lz    = '0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && raw_mag[i]) begin
        found = 1'b1;
        lz    = 6'(63 - i);
      end
    end
    dec.mag = raw_mag << lz;
    dec.exp = raw_exp - $signed({7'b0, lz});
  end

endmodule

// ----- rtl/wncu_round.sv -----
// ----------------------------------------------------------------------------
// wncu_round: alignment and round-to-nearest-even
// Trunc: shifts the mantissa to an integer. Conv/demote/promote: rounds.
// ----------------------------------------------------------------------------
module wncu_round (
  input  wncu_pkg::dec_t dec,
  output wncu_pkg::mid_t mid
);
  import wncu_pkg::*;

  logic [6:0]   sh;
  logic [127:0] wide;
  logic [63:0]  q;
  logic [63:0]  rem;
  logic [63:0]  half;
  logic         up;
  logic signed [12:0] e;
  logic [6:0]   rs;   // right shift of the 64-bit aligned value
  logic [64:0]  qe;

  always_comb begin
    mid.special = dec.special;
    mid.trap    = dec.trap;
    mid.res     = dec.res;
    mid.cls     = dec.cls;
    mid.neg     = dec.neg;
    mid.dst64   = dec.dst64;
    mid.sgn     = dec.sgn;
    mid.exp     = dec.exp;
    mid.val     = '0;
    mid.ovf     = 1'b0;
    sh = '0; wide = '0; q = '0; rem = '0; half = '0; up = 1'b0;
    e = dec.exp; rs = '0; qe = '0;

    if (dec.cls == CL_TRUNC) begin
      if (dec.exp >= 13'sd64) begin
        mid.ovf = 1'b1;
      end else if (dec.exp >= 13'sd0) begin
        sh = 7'(13'sd63 - dec.exp);
        mid.val = dec.mag >> sh;
      end
    end else begin
      // target mantissa width including hidden bit: 24 or 53
      if (dec.cls == CL_FLT && !dec.dst64 && dec.exp < -13'sd126) begin
        // demote to subnormal: value = mag * 2^(e-63), unit 2^-149
        if (dec.exp < -13'sd150) rs = 7'd64;
        else rs = 7'(13'sd63 - 13'sd149 - dec.exp);
      end else begin
        rs = dec.dst64 ? 7'd11 : 7'd40;
      end
      if (rs >= 7'd64) begin
        q = '0; rem = dec.mag; half = '0; up = (dec.exp == -13'sd150) &&
                                                 (dec.mag != 64'h8000000000000000);
        // exp == -151 or less with rs 64: value < 2^-150, rounds to 0
        if (dec.exp != -13'sd150) up = 1'b0;
      end else begin
        wide = {dec.mag, 64'b0} >> rs;
        q    = wide[127:64];
        rem  = wide[63:0];
        half = 64'h8000000000000000;
        up   = (rem > half) || (rem == half && q[0]);
      end
      qe = {1'b0, q} + {64'b0, up};
      mid.val = qe[63:0];
      e = dec.exp;
      if (rs == 7'd11 && qe[53]) begin
        mid.val = qe[63:0] >> 1; e = dec.exp + 13'sd1;
      end else if (rs == 7'd40 && qe[24]) begin
        mid.val = qe[63:0] >> 1; e = dec.exp + 13'sd1;
      end
      mid.exp = e;
    end
  end

endmodule

// ----- rtl/wncu_pack.sv -----
// ----------------------------------------------------------------------------
// wncu_pack: range checks and result assembly
// Applies truncation limits and packs sign, exponent and fraction.
// ----------------------------------------------------------------------------
module wncu_pack (
  input  wncu_pkg::mid_t mid,
  output logic [63:0]    result_bits,
  output logic           trap
);
  import wncu_pkg::*;

  logic [63:0] lim;
  logic [63:0] tmask;
  logic        bad;
  logic [10:0] be;

  always_comb begin
    result_bits = '0;
    trap        = 1'b0;
    lim         = mid.dst64 ? 64'h8000000000000000 : 64'h0000000080000000;
    tmask       = mid.dst64 ? '1 : 64'h00000000ffffffff;
    bad         = 1'b0;
    be          = '0;
    if (mid.special) begin
      result_bits = mid.res;
      trap        = mid.trap;
    end else if (mid.cls == CL_TRUNC) begin
      if (mid.sgn) bad = mid.ovf || (mid.neg ? (mid.val > lim) : (mid.val >= lim));
      else         bad = mid.ovf || (mid.neg && mid.val != '0) || (mid.val > tmask);
      trap = bad;
      if (!bad) result_bits = (mid.neg ? -mid.val : mid.val) & tmask;
    end else if (mid.dst64) begin
      be = 11'(mid.exp + 13'sd1023);
      result_bits = {mid.neg, be, mid.val[51:0]};
    end else if (mid.cls == CL_FLT && mid.exp < -13'sd126) begin
      // subnormal demote; a carry into bit 23 yields the min normal pattern
      result_bits = {32'b0, mid.neg, 31'(mid.val)};
    end else if (mid.exp > 13'sd127) begin
      result_bits = {32'b0, mid.neg, 31'h7f800000};
    end else begin
      be = 11'(mid.exp + 13'sd127);
      result_bits = {32'b0, mid.neg, be[7:0], mid.val[22:0]};
    end
  end

endmodule

// ----- rtl/wasm_numeric_conversion_unit_top.sv -----
// ----------------------------------------------------------------------------
// wasm_numeric_conversion_unit_top: Wasm conversion operators, pipelined
//
//   channel | valid     | stall     | payload
//   in      | in_valid  | in_stall  | in_func, in_operand_bits
//   out     | out_valid | out_stall | out_result_bits, out_trap
//
// One item per cycle while out_stall is low; decode/normalize, round,
// pack each end in a register. A stage loads when the stage after it is
// empty or moving on, so gaps close up under out_stall; in_stall rises
// only when all three stages hold items and out_stall is high.
// Reset empties the pipe.
// ----------------------------------------------------------------------------
module wasm_numeric_conversion_unit_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wncu_pkg::FUNC_W-1:0] in_func,
  input  logic [wncu_pkg::DATA_W-1:0] in_operand_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wncu_pkg::DATA_W-1:0] out_result_bits,
  output logic                        out_trap
);
  import wncu_pkg::*;

  dec_t        dec, dec_r;
  mid_t        mid, mid_r;
  logic [63:0] res;
  logic        trp;
  logic        v1_r, v2_r, v3_r;
  logic        adv3, adv2, adv1;
  logic [63:0] res_r;
  logic        trap_r;

  assign adv3 = !v3_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;

  wncu_decode u_dec (.func(in_func), .operand_bits(in_operand_bits), .dec(dec));
  wncu_round  u_rnd (.dec(dec_r), .mid(mid));
  wncu_pack   u_pck (.mid(mid_r), .result_bits(res), .trap(trp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) dec_r <= dec;
    if (adv2) mid_r <= mid;
    if (adv3) begin
      res_r  <= res;
      trap_r <= trp;
    end
  end

  assign out_valid       = v3_r;
  assign out_result_bits = res_r;
  assign out_trap        = trap_r;

endmodule

// ----- rtl/wncu_checker.sv -----
// ----------------------------------------------------------------------------
// wncu_checker: port-level checks of the conversion unit
// Output handshake and result consistency seen at the top level.
// ----------------------------------------------------------------------------
module wncu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_result_bits,
  input logic        out_trap
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_bits))
    else $error("stalled result changed");
  a_trapzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trap |-> out_result_bits == 64'b0)
    else $error("trap with nonzero result");
  a_nostall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output drains");
  a_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind wasm_numeric_conversion_unit_top wncu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_result_bits(out_result_bits), .out_trap(out_trap));
